// ===== sv/lpht_pkg.sv =====
// Package for the linear-probing hash table: slot layout, opcodes, status codes,
// sequencer states and the single-round integer mix function.
// No dependencies; used by lpht_mix and linear_probe_int_hash_table_top.
package lpht_pkg;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_PUT    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam int MIX_ROUNDS = 6;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] value;
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESP
    } state_t;

    // One round of the six-round mix; the round number selects constant and shift.
    function automatic logic [31:0] mix_round(input logic [31:0] a, input logic [2:0] rnd);
        logic [31:0] r;
        r = a;
        case (rnd)
            3'd0:    r = (a + 32'h7ed55d16) + (a << 12);
            3'd1:    r = (a ^ 32'hc761c23c) ^ (a >> 19);
            3'd2:    r = (a + 32'h165667b1) + (a << 5);
            3'd3:    r = (a + 32'hd3a2646c) ^ (a << 9);
            3'd4:    r = (a + 32'hfd7046c5) + (a << 3);
            3'd5:    r = (a ^ 32'hb55a4f09) ^ (a >> 16);
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/linear_probe_int_hash_table_top.sv =====
// Linear-probing hash table of 32-bit keys and values, top level.
// Depends on lpht_pkg, lpht_mix and lpht_ram.
//
// Each input beat is a get, put or remove and yields exactly one result beat.
// After reset the block sweeps the slot memory once, one slot a cycle, and
// s_tready stays low until the sweep is done. An operation then goes through
// acceptance, the six mix rounds of the iterative mix unit, the modulo
// reduction steps when TABLE_DEPTH is not a power of two, the hand-off of the
// home slot to the prober, the probe (one slot read per cycle on the single
// memory read port, each compared in the next cycle, stopping at the first hit
// or after PROBE_LIMIT slots), and the load of the result register. A put
// refused because the table is half full, and an unused opcode, skip hashing
// and go straight to the result register. Any write-back happens in the probe
// cycle that finds the slot. s_tready is high only while the sequencer is
// idle, and a result waiting on m_tready holds the sequencer before it returns
// to idle.
module linear_probe_int_hash_table_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int PROBE_LIMIT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // opcode[1:0], key[33:2], value[65:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], value_out[33:2], entry_total[41:34], pad
);
    import lpht_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int HALF   = TABLE_DEPTH / 2;
    localparam int CNT_W  = $clog2(HALF + 1);
    localparam int PC_W   = $clog2(PROBE_LIMIT + 1);
    localparam int SLOT_W = $bits(slot_t);

    state_t state_reg, state_next;

    logic [1:0]       op_reg, op_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      val_reg, val_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] pend_slot_reg, pend_slot_next;
    logic             pend_reg, pend_next;
    logic [PC_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic [PC_W-1:0]  chk_cnt_reg, chk_cnt_next;
    logic [1:0]       stat_reg, stat_next;
    logic [31:0]      found_reg, found_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;
    logic [47:0]      m_data_reg, m_data_next;

    logic             accept;
    logic [1:0]       in_op;
    logic             early_done;
    logic             probe_hit;
    logic             probe_last;
    logic             out_free;

    logic             mix_start;
    logic             mix_done;
    logic [IDX_W-1:0] mix_home;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_slot;
    logic             rd_en;
    slot_t            rd_slot;
    logic [SLOT_W-1:0] rd_bits;
    logic [31:0]      count_ext;

    // The mix unit loads the key straight from the accepted beat.
    lpht_mix #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mix (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mix_start),
        .key_in (key_next),
        .done   (mix_done),
        .home   (mix_home)
    );

    lpht_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_slot),
        .rd_en  (rd_en),
        .rd_addr(slot_reg),
        .rd_data(rd_bits)
    );

    assign rd_slot  = slot_t'(rd_bits);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = s_tdata[1:0];
    assign out_free = !m_valid_reg || m_tready;

    // Refused put and unused opcode answer without touching the table.
    assign early_done = (in_op == OP_PUT && count_reg >= CNT_W'(HALF))
                     || (in_op != OP_GET && in_op != OP_PUT && in_op != OP_REMOVE);

    always_comb begin
        probe_hit = 1'b0;
        if (pend_reg) begin
            if (op_reg == OP_PUT) begin
                probe_hit = !rd_slot.valid || rd_slot.key == key_reg;
            end else begin
                probe_hit = rd_slot.valid && rd_slot.key == key_reg;
            end
        end
    end

    assign probe_last = pend_reg && (chk_cnt_reg == PC_W'(PROBE_LIMIT - 1));

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) state_next = early_done ? S_RESP : S_HASH;
            end
            S_HASH: begin
                if (mix_done) state_next = S_PROBE;
            end
            S_PROBE: begin
                if (probe_hit || probe_last) state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic
    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        pend_slot_next = pend_slot_reg;
        pend_next      = 1'b0;
        iss_cnt_next   = iss_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        stat_next      = stat_reg;
        found_next     = found_reg;
        clr_next       = clr_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        s_tready       = 1'b0;
        mix_start      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pend_slot_reg;
        wr_slot        = '{valid: 1'b0, key: key_reg, value: val_reg};
        count_ext      = 32'(count_reg);

        case (state_reg)
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_slot  = '0;
                clr_next = clr_reg + IDX_W'(1);
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    op_next    = in_op;
                    key_next   = s_tdata[33:2];
                    val_next   = s_tdata[65:34];
                    found_next = '0;
                    stat_next  = (in_op == OP_PUT) ? STAT_FULL : STAT_MISSING;
                    mix_start  = !early_done;
                end
            end
            S_HASH: begin
            end
            S_PROBE: begin
                // Issue the next read while checking the one that came back.
                if (iss_cnt_reg < PC_W'(PROBE_LIMIT)) begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    iss_cnt_next = iss_cnt_reg + PC_W'(1);
                    pend_slot_next = slot_reg;
                    slot_next    = (slot_reg == IDX_W'(TABLE_DEPTH - 1)) ? '0
                                                                         : slot_reg + IDX_W'(1);
                end
                if (pend_reg) begin
                    chk_cnt_next = chk_cnt_reg + PC_W'(1);
                end
                if (probe_hit) begin
                    stat_next = STAT_OK;
                    case (op_reg)
                        OP_GET: begin
                            found_next = rd_slot.value;
                        end
                        OP_PUT: begin
                            wr_en   = 1'b1;
                            wr_slot = '{valid: 1'b1, key: key_reg, value: val_reg};
                            if (!rd_slot.valid) count_next = count_reg + CNT_W'(1);
                        end
                        default: begin
                            wr_en = 1'b1;
                            if (count_reg != '0) count_next = count_reg - CNT_W'(1);
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, count_ext[7:0], found_reg, stat_reg};
                end
            end
            default: begin
            end
        endcase

        if (mix_done) begin
            slot_next    = mix_home;
            iss_cnt_next = '0;
            chk_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        slot_reg      <= slot_next;
        pend_slot_reg <= pend_slot_next;
        iss_cnt_reg   <= iss_cnt_next;
        chk_cnt_reg   <= chk_cnt_next;
        stat_reg      <= stat_next;
        found_reg     <= found_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== sv/lpht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lpht_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lpht_mix.sv =====
// Iterative key hash: one mix round per cycle on a shared add/xor/shift stage,
// then, for a depth that is not a power of two, one restoring reduction step per cycle.
// Depends on lpht_pkg.
module lpht_mix #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [31:0]                    key_in,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] home
);
    import lpht_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam bit POW2      = ((1 << IDX_W) == TABLE_DEPTH);
    localparam int MOD_STEPS = 34 - IDX_W;
    localparam int LAST_STEP = POW2 ? (MIX_ROUNDS - 1) : (MIX_ROUNDS - 1 + MOD_STEPS);
    localparam int STEP_W    = $clog2(LAST_STEP + 1);
    // Largest shifted divisor; it exceeds any 32-bit value.
    localparam logic [33:0] SUB_INIT = 34'(TABLE_DEPTH) << (MOD_STEPS - 1);

    logic [31:0]       a_reg, a_next;
    logic [33:0]       sub_reg, sub_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    always_comb begin
        a_next    = a_reg;
        sub_next  = sub_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = key_in;
            sub_next  = SUB_INIT;
            step_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            if (step_reg < STEP_W'(MIX_ROUNDS)) begin
                a_next = mix_round(a_reg, step_reg[2:0]);
            end else begin
                if ({2'b00, a_reg} >= sub_reg) begin
                    a_next = a_reg - sub_reg[31:0];
                end
                sub_next = sub_reg >> 1;
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(LAST_STEP)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        a_reg    <= a_next;
        sub_reg  <= sub_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign home = a_reg[IDX_W-1:0];

endmodule

// ===== sim/lpht_checker.sv =====
`timescale 1ns / 100ps
// Checker for the linear-probing hash table: slot-index helper package plus a monitor that
// predicts every answer from its own table copy. Depends on lpht_pkg.
package lpht_tb_pkg;

    localparam int TB_DEPTH = 256;
    localparam int TB_REACH = 8;

    // opcode with no operation behind it; the block answers "missing"
    localparam logic [1:0] OP_UNUSED = 2'd3;

    function automatic logic [31:0] scramble(input logic [31:0] x);
        logic [31:0] h;
        h = x;
        h = h + 32'h7ed55d16 + (h << 12);
        h = h ^ 32'hc761c23c ^ (h >> 19);
        h = h + 32'h165667b1 + (h << 5);
        h = (h + 32'hd3a2646c) ^ (h << 9);
        h = h + 32'hfd7046c5 + (h << 3);
        h = h ^ 32'hb55a4f09 ^ (h >> 16);
        return h;
    endfunction

    function automatic logic [7:0] home_of(input logic [31:0] k);
        logic [31:0] h;
        h = scramble(k);
        return h[7:0];
    endfunction

endpackage

module lpht_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // opcode[1:0], key[33:2], value[65:34], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // status[1:0], value_out[33:2], entry_total[41:34], pad
    output int          fail_count,
    output int          outstanding
);
    import lpht_pkg::*;
    import lpht_tb_pkg::*;

    // field order matches m_tdata, lowest field last
    typedef struct packed {
        logic [7:0]  total;
        logic [31:0] found;
        logic [1:0]  status;
    } answer_t;

    bit          used [TB_DEPTH];
    logic [31:0] keys [TB_DEPTH];
    logic [31:0] vals [TB_DEPTH];
    int unsigned live;
    int          misses;
    answer_t     answer_q [$];

    initial begin
        fail_count  = 0;
        outstanding = 0;
        misses      = 0;
        live        = 0;
    end

    // Applies one operation to the shadow table and returns the answer it should give.
    // Slot index is 8 bits, so s + 1 wraps from 255 to 0 on its own.
    function automatic answer_t table_op(input logic [1:0] op, input logic [31:0] k,
                                         input logic [31:0] v);
        answer_t    a;
        logic [7:0] s;
        bit         hit;
        a.status = STAT_MISSING;
        a.found  = '0;
        hit      = 1'b0;
        s        = home_of(k);
        case (op)
            OP_GET: begin
                // empty slots do not end the search
                for (int i = 0; i < TB_REACH; i++) begin
                    if (!hit && used[s] && keys[s] == k) begin
                        hit      = 1'b1;
                        a.status = STAT_OK;
                        a.found  = vals[s];
                    end
                    s = s + 8'd1;
                end
            end
            OP_PUT: begin
                a.status = STAT_FULL;
                if (live < TB_DEPTH / 2) begin
                    for (int i = 0; i < TB_REACH; i++) begin
                        if (!hit && (!used[s] || keys[s] == k)) begin
                            if (!used[s])
                                live++;
                            used[s]  = 1'b1;
                            keys[s]  = k;
                            vals[s]  = v;
                            hit      = 1'b1;
                            a.status = STAT_OK;
                        end
                        s = s + 8'd1;
                    end
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < TB_REACH; i++) begin
                    if (!hit && used[s] && keys[s] == k) begin
                        hit      = 1'b1;
                        used[s]  = 1'b0;
                        if (live > 0)
                            live--;
                        a.status = STAT_OK;
                    end
                    s = s + 8'd1;
                end
            end
            default: ;
        endcase
        a.total = live[7:0];
        return a;
    endfunction

    always @(posedge aclk) begin : watch
        answer_t want;
        answer_t got;
        if (!aresetn) begin
            for (int i = 0; i < TB_DEPTH; i++)
                used[i] = 1'b0;
            live = 0;
            answer_q.delete();
        end else begin
            // result side first: a result beat always belongs to an older op
            if (m_tvalid && m_tready) begin
                got = answer_t'(m_tdata[41:0]);
                if (answer_q.size() == 0) begin
                    misses++;
                    if (misses <= 10)
                        $display("%0t unexpected result beat: status %0d value %h total %0d",
                                 $realtime, got.status, got.found, got.total);
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.total !== want.total) begin
                        misses++;
                        if (misses <= 10)
                            $display("%0t mismatch exp/act: st %0d/%0d val %h/%h tot %0d/%0d",
                                     $realtime, want.status, got.status, want.found,
                                     got.found, want.total, got.total);
                    end
                end
            end
            if (s_tvalid && s_tready)
                answer_q.push_back(table_op(s_tdata[1:0], s_tdata[33:2], s_tdata[65:34]));
        end
        outstanding <= answer_q.size();
        fail_count  <= misses;
    end

endmodule

// ===== sim/tb_linear_probe_int_hash_table_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the linear-probing hash table: clock, reset, op stimulus and verdict.
// Depends on lpht_pkg, lpht_checker.sv (lpht_tb_pkg, lpht_checker) and the block's RTL.
module tb_linear_probe_int_hash_table_top;
    import lpht_pkg::*;
    import lpht_tb_pkg::*;

    localparam int STALL_LIMIT = 3000;  // covers the post-reset sweep and the long hold
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_SIZE   = 200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int          fail_count;
    int          outstanding;
    int          idle_cycles = 0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;
    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] chain [9];   // keys that all hash to the last slot

    linear_probe_int_hash_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lpht_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, bursts of back-to-back accepts, one long hold
    initial begin
        int gap;
        int beats;
        beats = 0;
        forever begin
            if (beats == HOLD_AFTER)
                gap = HOLD_CYCLES;
            else
                gap = recv_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            beats++;
        end
    end

    task automatic send_op(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, v, k, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly reuse known keys so gets and removes hit
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic random_phase(input int count, input int put_pct, input int get_pct,
                                input int rem_pct);
        int         roll;
        logic [1:0] op;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < put_pct)
                op = OP_PUT;
            else if (roll < put_pct + get_pct)
                op = OP_GET;
            else if (roll < put_pct + get_pct + rem_pct)
                op = OP_REMOVE;
            else
                op = OP_UNUSED;
            send_op(op, pick_key(), $urandom);
        end
    endtask

    initial begin
        logic [31:0] k;
        int          found;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        k     = $urandom;
        found = 0;
        while (found < 9) begin
            if (home_of(k) == 8'hff) begin
                chain[found]        = k;
                key_pool[4 + found] = k;
                found++;
            end
            k = k + 32'd1;
        end

        while (!aresetn) @(posedge aclk);

        send_op(OP_GET,    32'h0000_0000, 32'hffff_ffff);
        send_op(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
        send_op(OP_PUT,    32'h0000_0000, 32'h0000_0000);
        send_op(OP_PUT,    32'h8000_0000, 32'hffff_ffff);
        send_op(OP_PUT,    32'h7fff_ffff, 32'ha5a5_a5a5);
        send_op(OP_PUT,    32'hffff_ffff, 32'h5a5a_5a5a);
        send_op(OP_GET,    32'h8000_0000, 32'h0000_0000);
        send_op(OP_PUT,    32'h8000_0000, 32'h0000_0001);   // overwrite keeps the count
        send_op(OP_GET,    32'h8000_0000, 32'h0000_0000);
        send_op(OP_GET,    32'h7fff_ffff, 32'h0000_0000);
        send_op(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
        send_op(OP_GET,    32'h0000_0000, 32'h0000_0000);
        // eight keys on the last slot wrap around to slot 6; the ninth finds no room
        for (int i = 0; i < 9; i++)
            send_op(OP_PUT, chain[i], $urandom);
        send_op(OP_REMOVE, chain[0], 32'h0000_0000);
        send_op(OP_GET,    chain[7], 32'h0000_0000);     // hole in the run must not stop it
        send_op(OP_PUT,    chain[8], 32'hdead_beef);     // refills the freed home slot
        send_op(OP_PUT,    chain[7], 32'h1234_5678);
        send_op(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);

        random_phase(250, 80, 10, 5);   // fill toward half full
        random_phase(130, 35, 40, 20);
        random_phase(100, 10, 30, 55);  // drain
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
